// ----- rtl/hpnms_pkg.sv -----
// ----------------------------------------------------------------------------
// hpnms_pkg
// Shared types and constants for the heatmap peak detector.
// ----------------------------------------------------------------------------
package hpnms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WIDTH   = 256;
    localparam int COL_BITS    = 8;
    localparam int ROW_BITS    = 9;
    localparam int DIM_BITS    = 9;
    localparam int CNT_BITS    = 8;
    localparam int CH_BITS     = 8;
    localparam int CFG_IDX_BITS = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COL_BITS-1:0]           col_t;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PEAK_LIMIT     = 2'd3;

    localparam sample_t              RST_PEAK_THRESHOLD = 16'sd819;
    localparam logic [DIM_BITS-1:0]  RST_FRAME_WIDTH    = 9'd224;
    localparam logic [DIM_BITS-1:0]  RST_FRAME_HEIGHT   = 9'd224;
    localparam logic [CNT_BITS-1:0]  RST_PEAK_LIMIT     = 8'd100;

    localparam logic [DIM_BITS-1:0]  DIM_MAX = 9'd256;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // Line buffer access for one accepted beat
    typedef struct packed {
        logic    en;
        col_t    waddr;
        sample_t wcenter;
        sample_t wupper;
        col_t    right_addr;
        col_t    upper_addr;
    } lb_ctrl_t;

endpackage

// ----- rtl/heatmap_peak_nms.sv -----
// ----------------------------------------------------------------------------
// heatmap_peak_nms
// Four-neighbor local maximum detector over a raster heatmap stream.
// ----------------------------------------------------------------------------
// Samples enter on the item channel in raster order, one channel at a time,
// followed by one row of flush beats (req_type = 1) per channel. A pixel is
// decided when the beat directly below it arrives; peaks and the channel end
// leave on the result channel, at most one result beat per item beat.
// Throughput is one item per clock when not stalled. A result appears in
// the cycle after the item that caused it, held in a single output register;
// an item is taken whenever that register is empty or is being emptied in
// the same cycle, so a stalled receiver stops input only while a result waits.
// The window is a short chain of cells (center, left) fed from two row
// stores of 256 entries with registered reads each beat; the right
// neighbor and upper row are prefetched one beat ahead.
// Reset clears position, counters, channel number and the output valid flag
// and loads register defaults; row stores are not cleared, rows above the
// frame read as zero by position. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
module heatmap_peak_nms (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [hpnms_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [hpnms_pkg::SAMPLE_BITS-1:0]        cfg_data,
    input  logic                                     item_valid,
    output logic                                     item_ready,
    input  logic                                     req_type,
    input  logic signed [hpnms_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                     result_valid,
    input  logic                                     result_ready,
    output logic                                     is_peak,
    output logic [hpnms_pkg::COL_BITS-1:0]           peak_x,
    output logic [7:0]                               peak_y,
    output logic signed [hpnms_pkg::SAMPLE_BITS-1:0] peak_value,
    output logic [hpnms_pkg::CNT_BITS-1:0]           peak_count,
    output logic [hpnms_pkg::CH_BITS-1:0]            channel_index,
    output logic                                     channel_done,
    output logic                                     overflow
);

    // configuration
    hpnms_pkg::sample_t                  thr_reg;
    logic [hpnms_pkg::DIM_BITS-1:0]      fw_reg;
    logic [hpnms_pkg::DIM_BITS-1:0]      fh_reg;
    logic [hpnms_pkg::CNT_BITS-1:0]      lim_reg;

    // stream position and channel state
    hpnms_pkg::col_t                     x_reg, x_next;
    logic [hpnms_pkg::ROW_BITS-1:0]      y_reg, y_next;
    logic [hpnms_pkg::CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                                ovf_reg, ovf_next;
    logic [hpnms_pkg::CH_BITS-1:0]       ch_reg, ch_next;
    logic                                row_start_reg, row_start_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic                                o_peak_reg;
    hpnms_pkg::col_t                     o_x_reg;
    logic [7:0]                          o_y_reg;
    hpnms_pkg::sample_t                  o_val_reg;
    logic [hpnms_pkg::CNT_BITS-1:0]      o_cnt_reg;
    logic [hpnms_pkg::CH_BITS-1:0]       o_ch_reg;
    logic                                o_done_reg;
    logic                                o_ovf_reg;

    logic                                acc;
    logic [hpnms_pkg::DIM_BITS-1:0]      fw_eff, fh_eff;
    logic [hpnms_pkg::DIM_BITS-1:0]      x_plus1;
    logic [hpnms_pkg::ROW_BITS-1:0]      y_above;
    logic                                last_col, decide, cand, peak, done, emit;
    hpnms_pkg::sample_t                  v, c, top, left, right_raw, right, lb_head, lb_upper;
    hpnms_pkg::lb_ctrl_t                 lb_ctrl;

    assign acc        = item_valid && item_ready;
    assign item_ready = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= hpnms_pkg::RST_PEAK_THRESHOLD;
            fw_reg  <= hpnms_pkg::RST_FRAME_WIDTH;
            fh_reg  <= hpnms_pkg::RST_FRAME_HEIGHT;
            lim_reg <= hpnms_pkg::RST_PEAK_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hpnms_pkg::CFG_PEAK_THRESHOLD: thr_reg <= cfg_data;
                hpnms_pkg::CFG_FRAME_WIDTH:    fw_reg  <= cfg_data[hpnms_pkg::DIM_BITS-1:0];
                hpnms_pkg::CFG_FRAME_HEIGHT:   fh_reg  <= cfg_data[hpnms_pkg::DIM_BITS-1:0];
                hpnms_pkg::CFG_PEAK_LIMIT:     lim_reg <= cfg_data[hpnms_pkg::CNT_BITS-1:0];
                default:                       thr_reg <= thr_reg;
            endcase
        end
    end

    // clamp geometry to 1..256
    always_comb
    begin
        fw_eff = fw_reg;
        if (fw_reg == '0)
        begin
            fw_eff = 9'd1;
        end
        else if (fw_reg > hpnms_pkg::DIM_MAX)
        begin
            fw_eff = hpnms_pkg::DIM_MAX;
        end
        fh_eff = fh_reg;
        if (fh_reg == '0)
        begin
            fh_eff = 9'd1;
        end
        else if (fh_reg > hpnms_pkg::DIM_MAX)
        begin
            fh_eff = hpnms_pkg::DIM_MAX;
        end
    end

    assign x_plus1  = {1'b0, x_reg} + 9'd1;
    assign last_col = (x_plus1 >= fw_eff);
    assign y_above  = y_reg - 9'd1;
    assign decide   = (y_reg != '0) && (y_above < fh_eff);

    // window chain: line buffer right tap -> center cell -> left cell
    hpnms_cell u_center (
        .clk     (clk),
        .en      (acc),
        .din     (right_raw),
        .alt_sel (row_start_reg),
        .alt     (lb_head),
        .mask    (1'b0),
        .q       (c)
    );

    hpnms_cell u_left (
        .clk     (clk),
        .en      (acc),
        .din     (c),
        .alt_sel (1'b0),
        .alt     (c),
        .mask    (x_reg == '0),
        .q       (left)
    );

    assign v     = (req_type == hpnms_pkg::REQ_FLUSH) ? '0 : sample;
    assign top   = (y_reg >= 9'd2) ? lb_upper : '0;
    assign right = last_col ? '0 : right_raw;

    assign cand = (c >= thr_reg) && (c > top) && (c > v) && (c > left) && (c > right);
    assign peak = decide && cand && (cnt_reg < lim_reg);
    assign done = (req_type == hpnms_pkg::REQ_FLUSH) && last_col;
    assign emit = peak || done;

    always_comb
    begin
        lb_ctrl.en         = acc;
        lb_ctrl.waddr      = x_reg;
        lb_ctrl.wcenter    = v;
        lb_ctrl.wupper     = c;
        lb_ctrl.right_addr = last_col ? 8'd1 : x_reg + 8'd2;
        lb_ctrl.upper_addr = last_col ? 8'd0 : x_reg + 8'd1;
    end

    hpnms_line_buf u_line_buf (
        .clk      (clk),
        .ctrl     (lb_ctrl),
        .right    (right_raw),
        .row_head (lb_head),
        .upper    (lb_upper)
    );

    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        ch_next        = ch_reg;
        row_start_next = row_start_reg;
        if (acc)
        begin
            if (peak)
            begin
                cnt_next = cnt_reg + 8'd1;
            end
            else if (decide && cand)
            begin
                ovf_next = 1'b1;
            end
            row_start_next = last_col;
            if (last_col)
            begin
                x_next = '0;
                y_next = y_reg + 9'd1;
            end
            else
            begin
                x_next = x_plus1[hpnms_pkg::COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            ch_reg        <= '0;
            row_start_reg <= 1'b1;
        end
        else if (acc && done)
        begin
            x_reg         <= '0;
            y_reg         <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            ch_reg        <= ch_reg + 8'd1;
            row_start_reg <= 1'b1;
        end
        else
        begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            ch_reg        <= ch_next;
            row_start_reg <= row_start_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (acc && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && emit)
        begin
            o_peak_reg <= peak;
            o_x_reg    <= peak ? x_reg : '0;
            o_y_reg    <= peak ? y_above[7:0] : '0;
            o_val_reg  <= peak ? c : '0;
            o_cnt_reg  <= cnt_next;
            o_ch_reg   <= ch_reg;
            o_done_reg <= done;
            o_ovf_reg  <= ovf_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign is_peak       = o_peak_reg;
    assign peak_x        = o_x_reg;
    assign peak_y        = o_y_reg;
    assign peak_value    = o_val_reg;
    assign peak_count    = o_cnt_reg;
    assign channel_index = o_ch_reg;
    assign channel_done  = o_done_reg;
    assign overflow      = o_ovf_reg;

endmodule

// ----- rtl/hpnms_line_buf.sv -----
// ----------------------------------------------------------------------------
// hpnms_line_buf
// Center and upper row stores, one write and registered reads per beat.
// ----------------------------------------------------------------------------
module hpnms_line_buf (
    input  logic               clk,
    input  hpnms_pkg::lb_ctrl_t ctrl,
    output hpnms_pkg::sample_t right,
    output hpnms_pkg::sample_t row_head,
    output hpnms_pkg::sample_t upper
);

    hpnms_pkg::sample_t center_mem [hpnms_pkg::MAX_WIDTH];
    hpnms_pkg::sample_t upper_mem  [hpnms_pkg::MAX_WIDTH];

    hpnms_pkg::sample_t right_reg;
    hpnms_pkg::sample_t row_head_reg;
    hpnms_pkg::sample_t upper_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            center_mem[ctrl.waddr] <= ctrl.wcenter;
            upper_mem[ctrl.waddr]  <= ctrl.wupper;
        end
    end

    // Write-first bypass: a read of the column being written sees the new value
    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            right_reg    <= (ctrl.right_addr == ctrl.waddr) ? ctrl.wcenter
                                                            : center_mem[ctrl.right_addr];
            row_head_reg <= (ctrl.waddr == '0) ? ctrl.wcenter : center_mem[0];
            upper_reg    <= (ctrl.upper_addr == ctrl.waddr) ? ctrl.wupper
                                                            : upper_mem[ctrl.upper_addr];
        end
    end

    assign right    = right_reg;
    assign row_head = row_head_reg;
    assign upper    = upper_reg;

endmodule

// ----- rtl/hpnms_cell.sv -----
// ----------------------------------------------------------------------------
// hpnms_cell
// One tap of the sliding window: takes its neighbor's sample each beat.
// ----------------------------------------------------------------------------
module hpnms_cell (
    input  logic               clk,
    input  logic               en,
    input  hpnms_pkg::sample_t din,
    input  logic               alt_sel,
    input  hpnms_pkg::sample_t alt,
    input  logic               mask,
    output hpnms_pkg::sample_t q
);

    hpnms_pkg::sample_t val_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= din;
        end
    end

    // mask: neighbor lies outside the frame and reads as zero
    always_comb
    begin
        if (mask)
        begin
            q = '0;
        end
        else if (alt_sel)
        begin
            q = alt;
        end
        else
        begin
            q = val_reg;
        end
    end

endmodule

// ----- rtl/hpnms_checker.sv -----
// ----------------------------------------------------------------------------
// hpnms_checker
// Port-level checks on the peak detector, bound to the top level.
// ----------------------------------------------------------------------------
module hpnms_checker (
    input logic                                     clk,
    input logic                                     rst_n,
    input logic                                     item_ready,
    input logic                                     result_valid,
    input logic                                     result_ready,
    input logic                                     is_peak,
    input logic [hpnms_pkg::COL_BITS-1:0]           peak_x,
    input logic [7:0]                               peak_y,
    input logic signed [hpnms_pkg::SAMPLE_BITS-1:0] peak_value,
    input logic [hpnms_pkg::CNT_BITS-1:0]           peak_count,
    input logic                                     channel_done
);

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(peak_x)
            && $stable(peak_y) && $stable(peak_value) && $stable(peak_count))
        else $error("result beat changed while stalled");

    // every result reports a peak, a channel end, or both
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> is_peak || channel_done)
        else $error("result beat with no cause");

    a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !is_peak |-> peak_x == '0 && peak_y == '0 && peak_value == '0)
        else $error("summary beat carries peak fields");

    a_peak_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_peak |-> peak_count != '0)
        else $error("peak reported with zero count");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("input stalled with empty output");

endmodule

bind heatmap_peak_nms hpnms_checker u_hpnms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_peak      (is_peak),
    .peak_x       (peak_x),
    .peak_y       (peak_y),
    .peak_value   (peak_value),
    .peak_count   (peak_count),
    .channel_done (channel_done)
);

// ----- sim/heatmap_peak_nms_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heatmap_peak_nms_tb
// Self-checking bench for the streaming four-neighbor peak detector.
// ----------------------------------------------------------------------------
// A beat-level predictor of the line buffers, counters and channel state
// runs on every accepted item beat and queues the peak/summary reports it
// expects. Each result beat is checked field by field against the oldest one.
// Stimulus: a few hand-built frames, then random channels (well-formed
// frames, extra rows, early flush, stray flush beats, width shrink mid-row),
// and a frame whose out-of-range width clamps to full width, under changing
// back-pressure.
// ----------------------------------------------------------------------------

typedef struct {
    logic                            is_peak;
    hpnms_pkg::col_t                 x;
    logic [7:0]                      y;
    hpnms_pkg::sample_t              value;
    logic [hpnms_pkg::CNT_BITS-1:0]  count;
    logic [hpnms_pkg::CH_BITS-1:0]   chan;
    logic                            done;
    logic                            ovf;
} peak_report_t;

class nms_scoreboard;
    hpnms_pkg::sample_t              center_row [hpnms_pkg::MAX_WIDTH];
    hpnms_pkg::sample_t              upper_row [hpnms_pkg::MAX_WIDTH];
    hpnms_pkg::sample_t              left_hold;
    hpnms_pkg::col_t                 col;
    logic [hpnms_pkg::ROW_BITS-1:0]  row;
    logic [hpnms_pkg::CNT_BITS-1:0]  found;
    logic                            ovf;
    logic [hpnms_pkg::CH_BITS-1:0]   channel;
    hpnms_pkg::sample_t              thr;
    logic [hpnms_pkg::DIM_BITS-1:0]  fw;
    logic [hpnms_pkg::DIM_BITS-1:0]  fh;
    logic [hpnms_pkg::CNT_BITS-1:0]  limit;
    peak_report_t                    pending_reports [$];
    int                              errors;

    function new();
        errors = 0;
        reset_state();
    endfunction

    function void reset_state();
        foreach (center_row[i])
        begin
            center_row[i] = '0;
            upper_row[i]  = '0;
        end
        left_hold = '0;
        col       = '0;
        row       = '0;
        found     = '0;
        ovf       = 1'b0;
        channel   = '0;
        thr       = hpnms_pkg::RST_PEAK_THRESHOLD;
        fw        = hpnms_pkg::RST_FRAME_WIDTH;
        fh        = hpnms_pkg::RST_FRAME_HEIGHT;
        limit     = hpnms_pkg::RST_PEAK_LIMIT;
        pending_reports.delete();
    endfunction

    function void apply_register(logic [hpnms_pkg::CFG_IDX_BITS-1:0] idx,
                                 logic [15:0] data);
        case (idx)
            hpnms_pkg::CFG_PEAK_THRESHOLD: thr   = data;
            hpnms_pkg::CFG_FRAME_WIDTH:    fw    = data[hpnms_pkg::DIM_BITS-1:0];
            hpnms_pkg::CFG_FRAME_HEIGHT:   fh    = data[hpnms_pkg::DIM_BITS-1:0];
            hpnms_pkg::CFG_PEAK_LIMIT:     limit = data[hpnms_pkg::CNT_BITS-1:0];
            default: ;
        endcase
    endfunction

    function int outstanding();
        return pending_reports.size();
    endfunction

    // Advance the window by one item beat; the pixel above it is decided now.
    function void take_item(logic req, hpnms_pkg::sample_t smp);
        int           w, h, x, y, v, c, top, lft, rgt;
        bit           last_col, done, peak;
        peak_report_t r;
        w = fw;
        if (w == 0) w = 1;
        if (w > hpnms_pkg::MAX_WIDTH) w = hpnms_pkg::MAX_WIDTH;
        h = fh;
        if (h == 0) h = 1;
        if (h > int'(hpnms_pkg::DIM_MAX)) h = int'(hpnms_pkg::DIM_MAX);
        x = col;
        y = row;
        // after a width shrink the column may sit past the new edge
        last_col = (x + 1 >= w);
        v = (req == hpnms_pkg::REQ_FLUSH) ? 0 : smp;
        c = center_row[x];
        peak = 1'b0;
        if (y >= 1 && y - 1 < h)
        begin
            top = (y >= 2) ? upper_row[x] : 0;
            lft = (x == 0) ? 0 : left_hold;
            rgt = (last_col || x + 1 >= hpnms_pkg::MAX_WIDTH) ? 0 : center_row[x + 1];
            if (c >= thr && c > top && c > v && c > lft && c > rgt)
            begin
                if (found < limit)
                begin
                    found = found + 1'b1;
                    peak  = 1'b1;
                end
                else
                    ovf = 1'b1;
            end
        end
        left_hold     = c;
        upper_row[x]  = c;
        center_row[x] = v;
        done = (req == hpnms_pkg::REQ_FLUSH) && last_col;
        if (peak || done)
        begin
            r.is_peak = peak;
            r.x       = peak ? hpnms_pkg::col_t'(x) : '0;
            r.y       = peak ? 8'(y - 1) : '0;
            r.value   = peak ? hpnms_pkg::sample_t'(c) : '0;
            r.count   = found;
            r.chan    = channel;
            r.done    = done;
            r.ovf     = ovf;
            pending_reports = {pending_reports, r};
        end
        if (done)
        begin
            col       = '0;
            row       = '0;
            left_hold = '0;
            found     = '0;
            ovf       = 1'b0;
            channel   = channel + 1'b1;
        end
        else if (last_col)
        begin
            col = '0;
            row = row + 1'b1;
        end
        else
            col = hpnms_pkg::col_t'(x + 1);
    endfunction

    function void match_field(string field, logic signed [31:0] want,
                              logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_report(peak_report_t got);
        peak_report_t want;
        if (pending_reports.size() == 0)
        begin
            $display("%0t: unexpected result beat: is_peak=%0d x=%0d y=%0d done=%0d",
                     $time, got.is_peak, got.x, got.y, got.done);
            errors++;
            return;
        end
        want = pending_reports.pop_front();
        match_field("is_peak", want.is_peak, got.is_peak);
        match_field("peak_x", want.x, got.x);
        match_field("peak_y", want.y, got.y);
        match_field("peak_value", want.value, got.value);
        match_field("peak_count", want.count, got.count);
        match_field("channel_index", want.chan, got.chan);
        match_field("channel_done", want.done, got.done);
        match_field("overflow", want.ovf, got.ovf);
    endfunction
endclass

module heatmap_peak_nms_tb;

    localparam int STALL_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 3;
    localparam int PHASE_ITEMS   = 130;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_write;
    logic [hpnms_pkg::CFG_IDX_BITS-1:0]    cfg_index;
    logic [hpnms_pkg::SAMPLE_BITS-1:0]     cfg_data;
    logic                                  item_valid;
    logic                                  item_ready;
    logic                                  req_type;
    hpnms_pkg::sample_t                    sample;
    logic                                  result_valid;
    logic                                  result_ready;
    logic                                  is_peak;
    hpnms_pkg::col_t                       peak_x;
    logic [7:0]                            peak_y;
    hpnms_pkg::sample_t                    peak_value;
    logic [hpnms_pkg::CNT_BITS-1:0]        peak_count;
    logic [hpnms_pkg::CH_BITS-1:0]         channel_index;
    logic                                  channel_done;
    logic                                  overflow;

    nms_scoreboard sb;
    int            snd_idle_pct;
    int            rcv_idle_pct;
    int            items_sent;
    int            hold_requests;

    heatmap_peak_nms dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .req_type      (req_type),
        .sample        (sample),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .is_peak       (is_peak),
        .peak_x        (peak_x),
        .peak_y        (peak_y),
        .peak_value    (peak_value),
        .peak_count    (peak_count),
        .channel_index (channel_index),
        .channel_done  (channel_done),
        .overflow      (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic hpnms_pkg::sample_t random_sample();
        case ($urandom_range(7))
            0: return hpnms_pkg::sample_t'($urandom);
            1: return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
            default: return hpnms_pkg::sample_t'($urandom_range(2400)) - 16'sd400;
        endcase
    endfunction

    task automatic write_register(input logic [hpnms_pkg::CFG_IDX_BITS-1:0] idx,
                                  input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.apply_register(idx, data);
        @(posedge clk);
    endtask

    // upper bits beyond each register's width carry junk on purpose
    task automatic program_regs(input logic [15:0] thr, input logic [8:0] fw,
                                input logic [8:0] fh, input logic [7:0] lim);
        write_register(hpnms_pkg::CFG_PEAK_THRESHOLD, thr);
        write_register(hpnms_pkg::CFG_FRAME_WIDTH, {7'($urandom), fw});
        write_register(hpnms_pkg::CFG_FRAME_HEIGHT, {7'($urandom), fh});
        write_register(hpnms_pkg::CFG_PEAK_LIMIT, {8'($urandom), lim});
        cfg_write <= 1'b0;
    endtask

    task automatic send_item(input logic req, input hpnms_pkg::sample_t smp);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        item_valid <= 1'b1;
        req_type   <= req;
        sample     <= smp;
        do @(posedge clk); while (!(item_valid && item_ready));
        sb.take_item(req, smp);
        items_sent++;
    endtask

    task automatic send_samples(input int n);
        repeat (n) send_item(hpnms_pkg::REQ_SAMPLE, random_sample());
    endtask

    // flush beats until the one at the last column ends the channel
    task automatic close_channel();
        logic [hpnms_pkg::CH_BITS-1:0] ch;
        ch = sb.channel;
        do send_item(hpnms_pkg::REQ_FLUSH, random_sample()); while (sb.channel == ch);
    endtask

    // a beat with no report may still be in flight when the queue empties
    task automatic settle();
        item_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic directed_frames();
        hpnms_pkg::sample_t grid [12];
        grid = '{16'sd100, 16'sh7FFF, 16'sd5, 16'sh8000,
                 16'sd7, 16'sd200, 16'sd300, -16'sd1,
                 16'sh8000, 16'sd50, 16'sh7FFF, 16'sd10};
        // limit of one: second peak is dropped and flags overflow
        program_regs(16'sd0, 9'd4, 9'd3, 8'd1);
        foreach (grid[i]) send_item(hpnms_pkg::REQ_SAMPLE, grid[i]);
        close_channel();
        // zero limit, lowest threshold, one row below the frame
        settle();
        program_regs(16'sh8000, 9'd2, 9'd1, 8'd0);
        send_item(hpnms_pkg::REQ_SAMPLE, 16'sd5);
        send_item(hpnms_pkg::REQ_SAMPLE, -16'sd3);
        send_item(hpnms_pkg::REQ_SAMPLE, 16'sd1);
        send_item(hpnms_pkg::REQ_SAMPLE, 16'sd2);
        close_channel();
        // highest threshold, only the max value qualifies
        settle();
        program_regs(16'sh7FFF, 9'd2, 9'd1, 8'd3);
        send_item(hpnms_pkg::REQ_SAMPLE, 16'sh7FFF);
        send_item(hpnms_pkg::REQ_SAMPLE, 16'sh7FFE);
        close_channel();
    endtask

    task automatic run_channel();
        logic [15:0] thr;
        logic [8:0]  fw;
        logic [8:0]  fh;
        logic [7:0]  lim;
        int          w, h, rows, n, sw;
        settle();
        case ($urandom_range(5))
            0: thr = 16'h8000;
            1: thr = 16'h7FFF;
            2: thr = 16'($urandom);
            default: thr = 16'($urandom_range(1500));
        endcase
        case ($urandom_range(9))
            0: fw = 9'd0;
            1: fw = 9'($urandom_range(16, 40));
            default: fw = 9'($urandom_range(1, 8));
        endcase
        case ($urandom_range(9))
            0: fh = 9'd0;
            1: fh = 9'($urandom_range(257, 511));
            default: fh = 9'($urandom_range(1, 6));
        endcase
        case ($urandom_range(5))
            0: lim = 8'd0;
            1: lim = 8'($urandom_range(5, 255));
            2: lim = 8'd255;
            default: lim = 8'($urandom_range(1, 4));
        endcase
        program_regs(thr, fw, fh, lim);
        w = (fw == 0) ? 1 : fw;
        h = (fh == 0) ? 1 : ((fh > 256) ? 256 : fh);
        // tall frames get cut short by an early flush
        rows = (h > 8) ? $urandom_range(1, 8) : h;
        case ($urandom_range(9))
            6: send_samples((rows + $urandom_range(1, 2)) * w);
            7: send_samples($urandom_range(rows * w));
            8: repeat (rows * w)
                   send_item(($urandom_range(3) == 0) ? hpnms_pkg::REQ_FLUSH
                                                      : hpnms_pkg::REQ_SAMPLE,
                             random_sample());
            9:
            begin
                n = $urandom_range(rows * w);
                send_samples(n);
                settle();
                sw = $urandom_range(1, w);
                program_regs(thr, 9'(sw), fh, lim);
                send_samples($urandom_range(rows * sw));
            end
            default: send_samples(rows * w);
        endcase
        close_channel();
    endtask

    // result side: checks every accepted beat, stalls at random or on request
    initial
    begin : result_sink
        peak_report_t got;
        int           hold_left;
        int           holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                got.is_peak = is_peak;
                got.x       = peak_x;
                got.y       = peak_y;
                got.value   = peak_value;
                got.count   = peak_count;
                got.chan    = channel_index;
                got.done    = channel_done;
                got.ovf     = overflow;
                sb.check_report(got);
            end
            if (hold_requests != holds_taken)
            begin
                hold_left   = HOLD_CYCLES;
                holds_taken = hold_requests;
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
                result_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_write)
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int goal;
        sb = new();
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= hpnms_pkg::CFG_PEAK_THRESHOLD;
        cfg_data      <= '0;
        item_valid    <= 1'b0;
        req_type      <= hpnms_pkg::REQ_SAMPLE;
        sample        <= '0;
        items_sent    = 0;
        hold_requests = 0;
        snd_idle_pct  = 18;
        rcv_idle_pct  = 47;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_frames();

        // long receiver stall while the sender keeps offering beats
        settle();
        program_regs(16'sh8000, 9'd4, 9'd6, 8'd255);
        hold_requests++;
        send_samples(24);
        close_channel();

        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) run_channel();

        snd_idle_pct = 47;
        rcv_idle_pct = 18;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) run_channel();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        goal = items_sent + PHASE_ITEMS;
        while (items_sent < goal) run_channel();

        // out-of-range width clamped to 256, flush row runs to the last column
        settle();
        program_regs(16'd0, 9'h12C, 9'd2, 8'd255);
        send_samples(5);
        close_channel();

        settle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
